[hw/rtl/echo_pulse_distance_meter_assert.svh]
// Assertion macros of the echo pulse distance meter RTL.
`ifndef ECHO_PULSE_DISTANCE_METER_ASSERT_SVH
`define ECHO_PULSE_DISTANCE_METER_ASSERT_SVH

// Clocked assertion, switched off while reset is high.
`define EPDM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define EPDM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/epdm_pkg.sv]
// Shared types and codes of the echo pulse distance meter.
`default_nettype none
package epdm_pkg;

   // operation codes of an input item
   localparam logic [1:0] OP_ARM     = 2'd0;
   localparam logic [1:0] OP_CAPTURE = 2'd1;
   localparam logic [1:0] OP_ABORT   = 2'd2;

   // result status codes
   localparam logic [1:0] ST_NONE      = 2'd0;
   localparam logic [1:0] ST_WAIT_FALL = 2'd1;
   localparam logic [1:0] ST_READY     = 2'd2;
   localparam logic [1:0] ST_TIMEOUT   = 2'd3;

   // measurement phases
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_RISE = 2'd1;
   localparam logic [1:0] PH_FALL = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   localparam int unsigned TICK_W  = 32;
   localparam int unsigned DIST_W  = 16;
   localparam int unsigned STEP_W  = 5;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TICK_W - 1);

   localparam logic [DIST_W-1:0] DIVISOR_RESET = 16'd58;
   localparam logic [DIST_W-1:0] DIST_SAT      = 16'hFFFF;

   typedef struct packed {
      logic take;      // input transfer this cycle
      logic div_step;  // one quotient bit
      logic div_last;  // final quotient bit
      logic load_out;  // move result into output register
   } ctrl_cmd_type;

   typedef struct packed {
      logic needs_div; // offered item is a falling-edge capture
   } dp_status_type;

endpackage
`default_nettype wire

[hw/rtl/epdm_ctrl.sv]
// Sequencer of the echo pulse distance meter: handshakes and divide control.
`default_nettype none
`include "echo_pulse_distance_meter_assert.svh"
module epdm_ctrl
   import epdm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          rsp_stall,
   input  wire dp_status_type status,
   output logic               req_stall,
   output logic               rsp_valid,
   output ctrl_cmd_type       cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_HOLD = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               step_in  = '0;
               state_in = status.needs_div ? S_DIV : S_HOLD;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               cmd.div_last = 1'b1;
               state_in     = S_HOLD;
            end
         end
         S_HOLD: begin
            // wait until the output register can take the result
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `EPDM_ASSERT(a_no_overwrite, clock, reset, cmd.load_out |-> out_free, "result overwritten")
   `EPDM_ASSERT(a_div_start, clock, reset, (cmd.take && status.needs_div) |=> (state_ff == S_DIV && step_ff == '0), "divide did not start")
   `EPDM_ASSERT(a_div_end, clock, reset, cmd.div_last |=> (state_ff == S_HOLD), "divide did not finish")
   `EPDM_ASSERT(a_div_stays, clock, reset, (state_ff == S_DIV) |=> (state_ff == S_DIV || state_ff == S_HOLD), "divide left early")

endmodule
`default_nettype wire

[hw/rtl/epdm_datapath.sv]
// Datapath of the echo pulse distance meter: measurement state, width, divider, result.
`default_nettype none
module epdm_datapath
   import epdm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [DIST_W-1:0]  csr_wr_data,
   input  wire logic [1:0]         req_operation,
   input  wire logic [2:0]         req_timer_id,
   input  wire logic [1:0]         req_channel,
   input  wire logic               req_wide_counter,
   input  wire logic [TICK_W-1:0]  req_capture_value,
   input  wire ctrl_cmd_type       cmd,
   output dp_status_type           status,
   output logic [1:0]              rsp_status,
   output logic [TICK_W-1:0]       rsp_pulse_ticks,
   output logic [DIST_W-1:0]       rsp_distance_cm
);

   // measurement state
   logic [DIST_W-1:0] divisor_ff;
   logic [1:0]        phase_ff, phase_in;
   logic [2:0]        timer_ff, timer_in;
   logic [1:0]        chan_ff, chan_in;
   logic              wide_ff, wide_in;
   logic [TICK_W-1:0] rise_ff, rise_in;

   // pending result
   logic [1:0]        res_status_ff, res_status_in;
   logic [TICK_W-1:0] res_ticks_ff, res_ticks_in;
   logic [DIST_W-1:0] res_dist_ff, res_dist_in;

   // divider: dividend shifts out as quotient shifts in
   logic [TICK_W-1:0] dvd_ff, dvd_in;
   logic [DIST_W-1:0] rem_ff, rem_in;
   logic [DIST_W:0]   trial;
   logic [DIST_W:0]   trial_diff;
   logic              trial_ge;

   // output register payload
   logic [1:0]        rsp_status_ff;
   logic [TICK_W-1:0] rsp_ticks_ff;
   logic [DIST_W-1:0] rsp_dist_ff;

   logic              match;
   logic [TICK_W-1:0] cap_sel;
   logic [TICK_W-1:0] width;
   logic [DIST_W-1:0] width_narrow;

   assign match = (req_operation == OP_CAPTURE) && (req_timer_id == timer_ff)
                  && (req_channel == chan_ff);
   assign cap_sel = wide_ff ? req_capture_value
                            : {{(TICK_W-DIST_W){1'b0}}, req_capture_value[DIST_W-1:0]};
   assign width_narrow = req_capture_value[DIST_W-1:0] - rise_ff[DIST_W-1:0];
   assign width = wide_ff ? (req_capture_value - rise_ff)
                          : {{(TICK_W-DIST_W){1'b0}}, width_narrow};

   assign status.needs_div = match && (phase_ff == PH_FALL);

   assign trial      = {rem_ff, dvd_ff[TICK_W-1]};
   assign trial_ge   = (trial >= {1'b0, divisor_ff});
   assign trial_diff = trial - {1'b0, divisor_ff};

   always_comb begin
      phase_in      = phase_ff;
      timer_in      = timer_ff;
      chan_in       = chan_ff;
      wide_in       = wide_ff;
      rise_in       = rise_ff;
      res_status_in = res_status_ff;
      res_ticks_in  = res_ticks_ff;
      res_dist_in   = res_dist_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;

      if (cmd.take) begin
         res_status_in = ST_NONE;
         res_ticks_in  = '0;
         res_dist_in   = '0;
         case (req_operation)
            OP_ARM: begin
               timer_in = req_timer_id;
               chan_in  = req_channel;
               wide_in  = req_wide_counter;
               phase_in = PH_RISE;
            end
            OP_ABORT: begin
               phase_in      = PH_IDLE;
               res_status_in = ST_TIMEOUT;
            end
            OP_CAPTURE: begin
               if (match && phase_ff == PH_RISE) begin
                  rise_in       = cap_sel;
                  phase_in      = PH_FALL;
                  res_status_in = ST_WAIT_FALL;
               end else if (match && phase_ff == PH_FALL) begin
                  phase_in      = PH_DONE;
                  res_status_in = ST_READY;
                  res_ticks_in  = width;
                  dvd_in        = width;
                  rem_in        = '0;
               end
            end
            default: begin
               res_status_in = ST_NONE;
            end
         endcase
      end

      if (cmd.div_step) begin
         rem_in = trial_ge ? trial_diff[DIST_W-1:0] : trial[DIST_W-1:0];
         dvd_in = {dvd_ff[TICK_W-2:0], trial_ge};
         if (cmd.div_last) begin
            // saturate quotient to the distance range
            res_dist_in = (|dvd_in[TICK_W-1:DIST_W]) ? DIST_SAT : dvd_in[DIST_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff <= DIVISOR_RESET;
         phase_ff   <= PH_IDLE;
         timer_ff   <= '0;
         chan_ff    <= '0;
         wide_ff    <= 1'b0;
         rise_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            divisor_ff <= csr_wr_data;
         end
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         chan_ff  <= chan_in;
         wide_ff  <= wide_in;
         rise_ff  <= rise_in;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_ticks_ff  <= res_ticks_in;
      res_dist_ff   <= res_dist_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      if (cmd.load_out) begin
         rsp_status_ff <= res_status_ff;
         rsp_ticks_ff  <= res_ticks_ff;
         rsp_dist_ff   <= res_dist_ff;
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_pulse_ticks = rsp_ticks_ff;
   assign rsp_distance_cm = rsp_dist_ff;

endmodule
`default_nettype wire

[hw/rtl/echo_pulse_distance_meter.sv]
// Top level of the echo pulse distance meter.
`default_nettype none
// Times one ultrasonic echo at a time and answers every input transfer with exactly one
// result. Arm, abort, rising-edge and ignored captures go into the pending result
// register at the transfer and move from the hold state into the output register once
// that register is free, which also opens the input again. A falling-edge capture first
// runs the bit-serial divider, forming one quotient bit per cycle over the 32-bit pulse
// width, before its hold state. One item is in work at a time; a finished
// result waits in the output register, and the next item is taken while it waits. That
// item's result then holds, with the input stalled, until the output register is free.
// distance_divisor resets to 58 and a divisor of zero reports distance 65535.
module echo_pulse_distance_meter
   import epdm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [DIST_W-1:0]  csr_wr_data,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_operation,
   input  wire logic [2:0]         req_timer_id,
   input  wire logic [1:0]         req_channel,
   input  wire logic               req_wide_counter,
   input  wire logic [TICK_W-1:0]  req_capture_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [TICK_W-1:0]       rsp_pulse_ticks,
   output logic [DIST_W-1:0]       rsp_distance_cm
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   epdm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   epdm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_operation     (req_operation),
      .req_timer_id      (req_timer_id),
      .req_channel       (req_channel),
      .req_wide_counter  (req_wide_counter),
      .req_capture_value (req_capture_value),
      .cmd               (cmd),
      .status            (status),
      .rsp_status        (rsp_status),
      .rsp_pulse_ticks   (rsp_pulse_ticks),
      .rsp_distance_cm   (rsp_distance_cm)
   );

endmodule
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the echo pulse distance meter.
`default_nettype none
module tb_top;
   import epdm_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT = 300000;
   localparam int         DRAIN_WAIT  = 40;
   localparam int         MAX_REPORTS = 10;
   localparam int         IDLE_MAX    = 13;

   typedef struct packed {
      logic [1:0]        operation;
      logic [2:0]        timer_id;
      logic [1:0]        channel;
      logic              wide_counter;
      logic [TICK_W-1:0] capture_value;
   } echo_req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [TICK_W-1:0] pulse_ticks;
      logic [DIST_W-1:0] distance_cm;
   } echo_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [DIST_W-1:0] csr_wr_data = '0;
   echo_req_type      drive_item = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_status;
   logic [TICK_W-1:0] rsp_pulse_ticks;
   logic [DIST_W-1:0] rsp_distance_cm;

   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   int   req_gap = 0;
   bit   req_burst = 1'b0;
   int   rsp_hold = 0;
   bit   rsp_burst = 1'b0;
   int   fail_count = 0;
   int   cycle_count = 0;

   echo_req_type    pending_echo_q[$];
   echo_result_type expected_echo_q[$];

   // predictor copy of the register and the measurement state
   logic [DIST_W-1:0] divisor_model;
   logic [1:0]        phase_model;
   logic [2:0]        watched_timer_model;
   logic [1:0]        watched_channel_model;
   logic              wide_model;
   logic [TICK_W-1:0] rise_stamp_model;

   echo_pulse_distance_meter i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (drive_item.operation),
      .req_timer_id      (drive_item.timer_id),
      .req_channel       (drive_item.channel),
      .req_wide_counter  (drive_item.wide_counter),
      .req_capture_value (drive_item.capture_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_pulse_ticks   (rsp_pulse_ticks),
      .rsp_distance_cm   (rsp_distance_cm)
   );

   always #10 clock = ~clock;

   function automatic echo_result_type measure_echo(input echo_req_type req);
      echo_result_type   res;
      logic [TICK_W-1:0] mask;
      logic [TICK_W-1:0] cap;
      logic [TICK_W-1:0] span;
      logic [TICK_W-1:0] quot;
      res = '0;
      res.status = ST_NONE;
      case (req.operation)
         OP_ARM: begin
            watched_timer_model = req.timer_id;
            watched_channel_model = req.channel;
            wide_model = req.wide_counter;
            phase_model = PH_RISE;
         end
         OP_ABORT: begin
            phase_model = PH_IDLE;
            res.status = ST_TIMEOUT;
         end
         OP_CAPTURE: begin
            if (req.timer_id == watched_timer_model && req.channel == watched_channel_model) begin
               mask = wide_model ? 32'hFFFF_FFFF : 32'h0000_FFFF;
               cap = req.capture_value & mask;
               if (phase_model == PH_RISE) begin
                  rise_stamp_model = cap;
                  phase_model = PH_FALL;
                  res.status = ST_WAIT_FALL;
               end else if (phase_model == PH_FALL) begin
                  // modular difference handles the counter wrap
                  span = (cap - (rise_stamp_model & mask)) & mask;
                  res.status = ST_READY;
                  res.pulse_ticks = span;
                  if (divisor_model == '0) begin
                     res.distance_cm = DIST_SAT;
                  end else begin
                     quot = span / {16'h0000, divisor_model};
                     res.distance_cm = (quot > 32'h0000_FFFF) ? DIST_SAT : quot[DIST_W-1:0];
                  end
                  phase_model = PH_DONE;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("%s", msg);
   endfunction

   // predict on every input transfer; the register is tracked as it is written
   always @(posedge clock) begin : predict_requests
      echo_req_type req;
      req_fire <= !reset && req_valid && !req_stall;
      if (reset) begin
         divisor_model = DIVISOR_RESET;
         phase_model = PH_IDLE;
         watched_timer_model = '0;
         watched_channel_model = '0;
         wide_model = 1'b0;
         rise_stamp_model = '0;
      end else begin
         if (csr_wr_en)
            divisor_model = csr_wr_data;
         if (req_valid && !req_stall) begin
            req = drive_item;
            expected_echo_q.push_back(measure_echo(req));
         end
      end
   end

   // hold the item until its transfer, then wait the drawn gap before the next
   always @(negedge clock) begin : drive_requests
      echo_req_type nxt_item;
      logic         nxt_valid;
      nxt_item = drive_item;
      nxt_valid = req_valid;
      if (req_valid && req_fire) begin
         nxt_valid = 1'b0;
         if ($urandom_range(0, 24) == 0)
            req_burst = !req_burst;
         req_gap = req_burst ? 0 : $urandom_range(0, IDLE_MAX);
      end
      if (!nxt_valid && !reset) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_echo_q.size() != 0) begin
            nxt_item = pending_echo_q.pop_front();
            nxt_valid = 1'b1;
         end
      end
      drive_item <= nxt_item;
      req_valid <= nxt_valid;
   end

   // stall the result side for a drawn number of cycles after each transfer
   always @(negedge clock) begin : stall_results
      if (rsp_fire) begin
         if ($urandom_range(0, 24) == 0)
            rsp_burst = !rsp_burst;
         rsp_hold = rsp_burst ? 0 : $urandom_range(0, IDLE_MAX);
      end
      rsp_stall <= (rsp_hold != 0);
      if (rsp_hold != 0)
         rsp_hold--;
   end

   always @(posedge clock) begin : check_results
      echo_result_type want;
      rsp_fire <= !reset && rsp_valid && !rsp_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_echo_q.size() == 0) begin
            note_failure($sformatf("unexpected result: status %0d ticks %0h dist %0d",
                                   rsp_status, rsp_pulse_ticks, rsp_distance_cm));
         end else begin
            want = expected_echo_q.pop_front();
            if (rsp_status != want.status || rsp_pulse_ticks != want.pulse_ticks ||
                rsp_distance_cm != want.distance_cm)
               note_failure($sformatf(
                  "mismatch: status exp %0d got %0d, ticks exp %0h got %0h, dist exp %0d got %0d",
                  want.status, rsp_status, want.pulse_ticks, rsp_pulse_ticks,
                  want.distance_cm, rsp_distance_cm));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic void push_item(input logic [1:0] op, input logic [2:0] tim,
                                     input logic [1:0] ch, input logic wide,
                                     input logic [TICK_W-1:0] cap);
      echo_req_type req;
      req.operation = op;
      req.timer_id = tim;
      req.channel = ch;
      req.wide_counter = wide;
      req.capture_value = cap;
      pending_echo_q.push_back(req);
   endfunction

   // bias values toward both counter wraps
   function automatic logic [TICK_W-1:0] random_capture();
      logic [TICK_W-1:0] r;
      r = $urandom;
      case ($urandom_range(0, 3))
         0: return r;
         1: return {r[31:16], 16'hFFFF - {8'h00, r[7:0]}};
         2: return 32'hFFFF_FFFF - (r & 32'h0000_00FF);
         default: return r & 32'h0000_FFFF;
      endcase
   endfunction

   // captures from a neighboring timer or channel, to be dropped
   function automatic void queue_foreign(input logic [2:0] tim, input logic [1:0] ch);
      int n;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      repeat (n) begin
         if ($urandom_range(0, 1))
            push_item(OP_CAPTURE, tim ^ 3'($urandom_range(1, 7)), ch,
                      1'($urandom_range(0, 1)), random_capture());
         else
            push_item(OP_CAPTURE, tim, ch ^ 2'($urandom_range(1, 3)),
                      1'($urandom_range(0, 1)), random_capture());
      end
   endfunction

   // one arm / rise / fall measurement with random content and random breaks
   function automatic int queue_echo_sequence();
      logic [2:0]        tim;
      logic [1:0]        ch;
      logic              wide;
      logic [TICK_W-1:0] rise;
      logic [TICK_W-1:0] delta;
      logic [TICK_W-1:0] fall;
      int                added;
      tim = 3'($urandom_range(0, 7));
      ch = 2'($urandom_range(0, 3));
      wide = 1'($urandom_range(0, 1));
      added = 0;
      if ($urandom_range(0, 9) == 0)
         push_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                   2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom);
      push_item(OP_ARM, tim, ch, wide, $urandom);
      added++;
      queue_foreign(tim, ch);
      if ($urandom_range(0, 15) == 0)
         push_item(OP_UNUSED, tim, ch, 1'($urandom_range(0, 1)), $urandom);
      if ($urandom_range(0, 11) == 0) begin
         push_item(OP_ABORT, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)), $urandom);
         return added + 1;
      end
      rise = random_capture();
      push_item(OP_CAPTURE, tim, ch, 1'($urandom_range(0, 1)), rise);
      added++;
      queue_foreign(tim, ch);
      case ($urandom_range(0, 9))
         0: begin
            push_item(OP_ABORT, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)), $urandom);
            added++;
         end
         1: begin
            push_item(OP_ARM, tim, ch, !wide, $urandom);
            added++;
         end
         default: begin
            case ($urandom_range(0, 3))
               0: delta = $urandom_range(0, 4000);
               1: delta = $urandom_range(0, 32'h0040_0000);
               2: delta = $urandom;
               default: delta = $urandom_range(0, 32'h0000_FFFF);
            endcase
            fall = rise + delta;
            if (!wide)
               fall[31:16] = 16'($urandom);
            push_item(OP_CAPTURE, tim, ch, 1'($urandom_range(0, 1)), fall);
            added++;
            // a late edge after the result is dropped
            if ($urandom_range(0, 7) == 0)
               push_item(OP_CAPTURE, tim, ch, 1'($urandom_range(0, 1)), $urandom);
            if ($urandom_range(0, 9) == 0) begin
               push_item(OP_ABORT, tim, ch, 1'($urandom_range(0, 1)), $urandom);
               added++;
            end
         end
      endcase
      return added;
   endfunction

   task automatic wait_drained();
      do
         @(posedge clock);
      while (pending_echo_q.size() != 0 || req_valid || expected_echo_q.size() != 0);
   endtask

   initial begin : stimulus
      logic [DIST_W-1:0] divisor_plan [8];
      int                queued;
      divisor_plan[0] = 16'd1;
      divisor_plan[1] = 16'hFFFF;
      divisor_plan[2] = 16'd0;
      divisor_plan[3] = 16'($urandom_range(3, 200));
      divisor_plan[4] = 16'd58;
      divisor_plan[5] = 16'($urandom_range(1, 16'hFFFF));
      divisor_plan[6] = 16'd2;
      divisor_plan[7] = 16'($urandom_range(201, 5000));

      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // nothing armed: capture dropped, unused operation, abort from idle
      push_item(OP_CAPTURE, 3'd0, 2'd0, 1'b0, 32'h0000_0000);
      push_item(OP_UNUSED, 3'd7, 2'd3, 1'b1, 32'hFFFF_FFFF);
      push_item(OP_ABORT, 3'd7, 2'd3, 1'b1, 32'hFFFF_FFFF);
      // wide counter across the 32-bit wrap, foreign timer and channel dropped
      push_item(OP_ARM, 3'd7, 2'd3, 1'b1, 32'h0000_0000);
      push_item(OP_CAPTURE, 3'd6, 2'd3, 1'b1, 32'h0000_0001);
      push_item(OP_CAPTURE, 3'd7, 2'd2, 1'b1, 32'h0000_0002);
      push_item(OP_CAPTURE, 3'd7, 2'd3, 1'b0, 32'hFFFF_FFF0);
      push_item(OP_CAPTURE, 3'd7, 2'd3, 1'b0, 32'h0000_0010);
      push_item(OP_CAPTURE, 3'd7, 2'd3, 1'b1, 32'h0000_1000);
      // narrow counter: upper bits dropped, 16-bit wrap
      push_item(OP_ARM, 3'd0, 2'd0, 1'b0, 32'hFFFF_FFFF);
      push_item(OP_CAPTURE, 3'd0, 2'd0, 1'b1, 32'hABCD_FFFE);
      push_item(OP_CAPTURE, 3'd0, 2'd0, 1'b1, 32'h1234_0001);
      // widest pulse saturates the distance
      push_item(OP_ARM, 3'd5, 2'd1, 1'b1, 32'h0000_0000);
      push_item(OP_CAPTURE, 3'd5, 2'd1, 1'b0, 32'h0000_0000);
      push_item(OP_CAPTURE, 3'd5, 2'd1, 1'b0, 32'hFFFF_FFFF);
      // rearm in mid-measurement, then a zero-width pulse
      push_item(OP_ARM, 3'd2, 2'd2, 1'b0, 32'h0000_0000);
      push_item(OP_CAPTURE, 3'd2, 2'd2, 1'b0, 32'h0000_0064);
      push_item(OP_ARM, 3'd2, 2'd2, 1'b1, 32'h0000_0000);
      push_item(OP_CAPTURE, 3'd2, 2'd2, 1'b1, 32'h8000_0005);
      push_item(OP_CAPTURE, 3'd2, 2'd2, 1'b1, 32'h8000_0005);
      // unused operation leaves the armed state alone; abort before the falling edge
      push_item(OP_ARM, 3'd1, 2'd1, 1'b0, 32'h0000_0000);
      push_item(OP_UNUSED, 3'd1, 2'd1, 1'b0, 32'h0000_0005);
      push_item(OP_CAPTURE, 3'd1, 2'd1, 1'b0, 32'h0000_0100);
      push_item(OP_ABORT, 3'd0, 2'd0, 1'b0, 32'h0000_0000);
      push_item(OP_CAPTURE, 3'd1, 2'd1, 1'b0, 32'h0000_0200);

      queued = 0;
      while (queued < 60)
         queued += queue_echo_sequence();
      wait_drained();

      foreach (divisor_plan[k]) begin
         @(negedge clock);
         csr_wr_en <= 1'b1;
         csr_wr_data <= divisor_plan[k];
         @(negedge clock);
         csr_wr_en <= 1'b0;
         queued = 0;
         while (queued < 52)
            queued += queue_echo_sequence();
         wait_drained();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0 && expected_echo_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
`default_nettype wire
